### hdl/abff_pkg.sv
// Package for the allocation bitmap find-first block.
// Holds sizes, operation codes, sequencer states and the lowest-bit encoder.
// No dependencies.
package abff_pkg;

  // Bitmap geometry
  localparam int unsigned WordBits = 64;
  localparam int unsigned Words    = 16;
  localparam int unsigned WordIdxW = 4;   // selects one of Words
  localparam int unsigned BitPosW  = 6;   // selects one bit of a word
  localparam int unsigned IdxW     = 10;  // bit number
  localparam int unsigned CfgW     = 5;   // words_in_use register
  localparam int unsigned OpW      = 3;

  localparam logic [CfgW-1:0] CfgReset  = CfgW'(16);
  localparam logic [CfgW-1:0] WordsCfg  = CfgW'(Words);

  // Stream payload widths (byte aligned)
  localparam int unsigned InDataW  = 16;  // operation, bit_index
  localparam int unsigned OutDataW = 16;  // found, found_index

  // Operation codes; code 7 has no meaning
  typedef enum logic [OpW-1:0] {
    OP_SET_BIT   = 3'd0,
    OP_CLR_BIT   = 3'd1,
    OP_TEST_BIT  = 3'd2,
    OP_FIND_SET  = 3'd3,
    OP_FIND_CLR  = 3'd4,
    OP_SET_ALL   = 3'd5,
    OP_CLR_ALL   = 3'd6
  } op_e;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_MOD  = 6'b000100,
    ST_SCAN = 6'b001000,
    ST_FILL = 6'b010000,
    ST_RES  = 6'b100000
  } state_e;

  // Position of the lowest set bit of a word (0 for an all-zero word)
  function automatic logic [BitPosW-1:0] lowest_bit(input logic [WordBits-1:0] w);
    logic [BitPosW-1:0] pos;
    pos = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (w[i]) pos = BitPosW'(i);
    end
    return pos;
  endfunction

endpackage

### hdl/allocation_bitmap_find_first.sv
// Bitmap allocator: set/clear/test a bit, find first set/clear bit, set/clear all.
// Set, clear and test read the addressed word, then modify and write it back or test it;
// find scans the words in use (one RAM word read per cycle) until a hit; set all writes
// every word in use (at most 16, one RAM write per cycle); others go straight to the result.
// One item at a time: s_axis_tready is high only while the sequencer is idle.
// Reset (async, active low) clears all bitmap words via per-word valid bits.
module allocation_bitmap_find_first (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration: words_in_use
  input  logic                           cfg_we_i,
  input  logic [abff_pkg::CfgW-1:0]      cfg_wdata_i,
  // input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [abff_pkg::InDataW-1:0]   s_axis_tdata_i,  // [2:0] operation, [12:3] bit_index
  // output stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [abff_pkg::OutDataW-1:0]  m_axis_tdata_o   // [0] found, [10:1] found_index
);

  import abff_pkg::*;

  state_e               state_q, state_d;
  logic [CfgW-1:0]      cfg_q;
  logic [CfgW-1:0]      act;
  logic [OpW-1:0]       op_q;
  logic [IdxW-1:0]      idx_q;
  logic [CfgW-1:0]      ptr_q, ptr_d;
  logic                 pend_q, pend_d;
  logic [Words-1:0]     vbits_q, vbits_d;
  logic                 rvld_q;
  logic                 res_found_q, res_found_d;
  logic [IdxW-1:0]      res_idx_q, res_idx_d;
  logic                 m_valid_q, m_valid_d;
  logic                 m_found_q;
  logic [IdxW-1:0]      m_idx_q;
  logic                 m_load;

  logic [OpW-1:0]       in_op;
  logic [IdxW-1:0]      in_idx;
  logic                 in_valid;
  logic                 accept;

  logic                 ram_we;
  logic [WordIdxW-1:0]  ram_waddr;
  logic [WordBits-1:0]  ram_wdata;
  logic [WordIdxW-1:0]  ram_raddr;
  logic [WordBits-1:0]  ram_rdata;
  logic [WordBits-1:0]  word_data;
  logic [WordBits-1:0]  hit_word;
  logic [WordBits-1:0]  bit_mask;
  logic [WordIdxW-1:0]  word_q;
  logic [BitPosW-1:0]   bit_q;
  logic [CfgW-1:0]      prev_ptr;

  // Bitmap storage
  abff_ram #(
    .Width (WordBits),
    .Depth (Words)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Input decode
  assign in_op    = s_axis_tdata_i[OpW-1:0];
  assign in_idx   = s_axis_tdata_i[OpW+IdxW-1:OpW];
  assign act      = (cfg_q > WordsCfg) ? WordsCfg : cfg_q;
  assign in_valid = {1'b0, in_idx[IdxW-1:BitPosW]} < act;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;

  assign word_q    = idx_q[IdxW-1:BitPosW];
  assign bit_q     = idx_q[BitPosW-1:0];
  assign bit_mask  = WordBits'(1) << bit_q;
  // A word never written since reset or clear all reads as zero
  assign word_data = rvld_q ? ram_rdata : '0;
  assign hit_word  = (op_q == OP_FIND_SET) ? word_data : ~word_data;
  assign prev_ptr  = ptr_q - CfgW'(1);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    vbits_d     = vbits_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    ram_we      = 1'b0;
    ram_waddr   = word_q;
    ram_wdata   = word_data;
    ram_raddr   = word_q;
    m_load      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_idx_d = in_idx;
          ptr_d     = '0;
          pend_d    = 1'b0;
          unique case (in_op)
            OP_SET_BIT, OP_CLR_BIT, OP_TEST_BIT: begin
              if (in_valid) begin
                state_d = ST_RD;
              end else begin
                res_found_d = 1'b0;
                state_d     = ST_RES;
              end
            end
            OP_FIND_SET, OP_FIND_CLR: state_d = ST_SCAN;
            OP_SET_ALL:               state_d = ST_FILL;
            OP_CLR_ALL: begin
              for (int i = 0; i < Words; i++) begin
                if (CfgW'(i) < act) vbits_d[i] = 1'b0;
              end
              res_found_d = 1'b1;
              state_d     = ST_RES;
            end
            default: begin
              res_found_d = 1'b0;
              state_d     = ST_RES;
            end
          endcase
        end
      end

      // issue read of the addressed word
      ST_RD: begin
        ram_raddr = word_q;
        state_d   = ST_MOD;
      end

      // read-modify-write or test
      ST_MOD: begin
        if (op_q == OP_TEST_BIT) begin
          res_found_d = word_data[bit_q];
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = word_q;
          ram_wdata       = (op_q == OP_SET_BIT) ? (word_data | bit_mask)
                                                 : (word_data & ~bit_mask);
          vbits_d[word_q] = 1'b1;
          res_found_d     = 1'b1;
        end
        state_d = ST_RES;
      end

      // one read issued and one word checked per cycle
      ST_SCAN: begin
        ram_raddr = ptr_q[WordIdxW-1:0];
        if (pend_q && (hit_word != '0)) begin
          res_found_d = 1'b1;
          res_idx_d   = {prev_ptr[WordIdxW-1:0], lowest_bit(hit_word)};
          state_d     = ST_RES;
        end else if (ptr_q == act) begin
          res_found_d = 1'b0;
          res_idx_d   = '0;
          state_d     = ST_RES;
        end else begin
          ptr_d  = ptr_q + CfgW'(1);
          pend_d = 1'b1;
        end
      end

      // write all ones to every word in use
      ST_FILL: begin
        if (ptr_q == act) begin
          res_found_d = 1'b1;
          state_d     = ST_RES;
        end else begin
          ram_we                         = 1'b1;
          ram_waddr                      = ptr_q[WordIdxW-1:0];
          ram_wdata                      = '1;
          vbits_d[ptr_q[WordIdxW-1:0]]   = 1'b1;
          ptr_d                          = ptr_q + CfgW'(1);
        end
      end

      // hand result to the output register once it is free
      ST_RES: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_load  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    m_valid_d = m_valid_q;
    if (m_load) m_valid_d = 1'b1;
    else if (m_axis_tready_i) m_valid_d = 1'b0;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cfg_q     <= CfgReset;
      ptr_q     <= '0;
      pend_q    <= 1'b0;
      vbits_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      pend_q    <= pend_d;
      vbits_q   <= vbits_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rvld_q      <= vbits_q[ram_raddr];
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    if (accept) begin
      op_q  <= in_op;
      idx_q <= in_idx;
    end
    if (m_load) begin
      m_found_q <= res_found_q;
      m_idx_q   <= res_idx_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - IdxW - 1)'(0), m_idx_q, m_found_q};

endmodule

### hdl/abff_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module abff_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
